// ===== rtl/abad_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// abad_pkg
// Shared types and constants for the adaptive binary arithmetic decoder.
// -----------------------------------------------------------------------------
package abad_pkg;

  localparam int unsigned RangeW      = 64;
  localparam int unsigned ProbW       = 32;
  localparam int unsigned CountW      = 28;
  localparam int unsigned OwedW       = 4;
  localparam int unsigned ContextBits = 8;

  localparam logic [OwedW-1:0]  OwedMax   = OwedW'(8);
  localparam logic [ProbW-1:0]  ProbReset = '1;
  localparam logic [CountW:0]   CountLim  = {1'b0, {CountW{1'b1}}};

  // Request kinds on the input channel.
  localparam logic ActFeed   = 1'b0;
  localparam logic ActDecode = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SPAN,
    S_MUL,
    S_MID,
    S_BIT,
    S_RD,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [CountW-1:0] zeros;
    logic [CountW-1:0] ones;
  } count_pair_t;

endpackage
`default_nettype wire

// ===== rtl/abad_div.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// abad_div
// Restoring divider for the next one-probability: ((ones+1) << 32) / (total+2),
// one quotient bit per cycle.
// -----------------------------------------------------------------------------
module abad_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire abad_pkg::count_pair_t         counts_i,
  output logic                               done_o,
  output logic [abad_pkg::ProbW-1:0]         quot_o
);

  localparam int unsigned RemW = abad_pkg::CountW + 1;
  localparam int unsigned DenW = abad_pkg::CountW + 2;
  localparam int unsigned StepW = $clog2(abad_pkg::ProbW);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [DenW-1:0]    den_q, den_d;
  logic [abad_pkg::ProbW-1:0] quot_q, quot_d;
  logic [DenW-1:0]    shifted;
  logic               fits;

  // The remainder starts below the divisor because ones + 1 < total + 2,
  // so the quotient takes exactly ProbW steps.
  always_comb begin
    shifted = {rem_q, 1'b0};
    fits    = (shifted >= den_q);
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quot_d  = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = RemW'(counts_i.ones) + RemW'(1);
      den_d  = DenW'(counts_i.zeros) + DenW'(counts_i.ones) + DenW'(2);
    end else if (busy_q) begin
      if (fits) begin
        rem_d = RemW'(shifted - den_q);
      end else begin
        rem_d = RemW'(shifted);
      end
      quot_d = {quot_q[abad_pkg::ProbW-2:0], fits};
      step_d = step_q + StepW'(1);
      if (step_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

// ===== rtl/adaptive_binary_arithmetic_decoder.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// adaptive_binary_arithmetic_decoder
// Binary arithmetic decoder with a 64-bit interval and a context-adaptive
// zero/one count model.
// -----------------------------------------------------------------------------
// Timing: a feed or refused request has its reply registered at the accepting
// edge; an accepted decode runs six setup steps (span, multiply, mid point,
// bit, count read, divider load), the 32-step probability divider and a done
// state that loads the reply once the output is free.
// Throughput: one feed per cycle while replies are taken; a decode holds
// the input off until its reply is loaded. Reset: a clearing pass zeroes all
// 2**CONTEXT_BITS count rows (256 by default); no request is taken meanwhile.
module adaptive_binary_arithmetic_decoder #(
  parameter int unsigned CONTEXT_BITS = abad_pkg::ContextBits
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        action_i,
  input  wire logic [7:0]                  data_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             decoded_bit_o,
  output logic [abad_pkg::OwedW-1:0]       bytes_owed_o,
  output logic                             refused_o
);

  localparam int unsigned RW = abad_pkg::RangeW;
  localparam int unsigned PW = abad_pkg::ProbW;
  localparam int unsigned CW = abad_pkg::CountW;
  localparam int unsigned OW = abad_pkg::OwedW;
  localparam int unsigned Depth = 2 ** CONTEXT_BITS;

  abad_pkg::state_e state_q, state_d;

  logic [RW-1:0]           low_q, high_q, code_q, mid_q;
  logic [PW-1:0]           span_q, prob_q;
  logic [RW-1:0]           prod_q;
  logic [CONTEXT_BITS-1:0] ctx_q, clr_q;
  logic [OW-1:0]           owed_q;
  logic                    bit_q;

  logic                    out_valid_q;
  logic                    res_bit_q, res_refused_q;
  logic [OW-1:0]           res_owed_q;

  abad_pkg::count_pair_t   mem [Depth];
  abad_pkg::count_pair_t   row_q, row_new;
  logic                    mem_we;
  logic [CONTEXT_BITS-1:0] mem_waddr;
  abad_pkg::count_pair_t   mem_wdata;

  logic                    accept, out_free, is_one, renorm, res_load;
  logic                    div_start, div_done;
  logic [PW-1:0]           div_quot;
  logic [CW:0]             bumped;

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;
  assign is_one   = (code_q <= mid_q);
  assign renorm   = (low_q[RW-1 -: 8] == high_q[RW-1 -: 8]) && (owed_q < abad_pkg::OwedMax);

  // Count update for the context just used; halve both when one overflows.
  always_comb begin
    row_new = row_q;
    if (is_one) begin
      bumped = {1'b0, row_q.ones} + (CW+1)'(1);
    end else begin
      bumped = {1'b0, row_q.zeros} + (CW+1)'(1);
    end
    if (bumped > abad_pkg::CountLim) begin
      row_new.zeros = row_q.zeros >> 1;
      row_new.ones  = row_q.ones >> 1;
      if (is_one) begin
        row_new.ones = bumped[CW:1];
      end else begin
        row_new.zeros = bumped[CW:1];
      end
    end else if (is_one) begin
      row_new.ones = bumped[CW-1:0];
    end else begin
      row_new.zeros = bumped[CW-1:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    res_load   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = ctx_q;
    mem_wdata  = row_new;
    case (state_q)
      abad_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == '1) begin
          state_d = abad_pkg::S_IDLE;
        end
      end
      abad_pkg::S_IDLE: begin
        in_ready_o = out_free;
        if (accept) begin
          if (action_i == abad_pkg::ActDecode && owed_q == '0) begin
            state_d = abad_pkg::S_SPAN;
          end else begin
            res_load = 1'b1;
          end
        end
      end
      abad_pkg::S_SPAN: state_d = abad_pkg::S_MUL;
      abad_pkg::S_MUL:  state_d = abad_pkg::S_MID;
      abad_pkg::S_MID:  state_d = abad_pkg::S_BIT;
      abad_pkg::S_BIT: begin
        mem_we  = 1'b1;
        state_d = abad_pkg::S_RD;
      end
      abad_pkg::S_RD:   state_d = abad_pkg::S_LOAD;
      abad_pkg::S_LOAD: begin
        div_start = 1'b1;
        state_d   = abad_pkg::S_DIV;
      end
      abad_pkg::S_DIV: begin
        if (div_done) begin
          state_d = abad_pkg::S_DONE;
        end
      end
      abad_pkg::S_DONE: begin
        if (out_free) begin
          res_load = 1'b1;
          state_d  = abad_pkg::S_IDLE;
        end
      end
      default: state_d = abad_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= abad_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Count store: one write port, one registered read at the current context.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    row_q <= mem[ctx_q];
  end

  abad_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .counts_i (row_q),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  always_ff @(posedge clk_i) begin
    span_q <= PW'((high_q - low_q) >> PW);
    prod_q <= RW'(span_q) * RW'(prob_q);
    mid_q  <= low_q + prod_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q         <= '0;
      high_q        <= '1;
      code_q        <= '0;
      ctx_q         <= '0;
      prob_q        <= abad_pkg::ProbReset;
      owed_q        <= abad_pkg::OwedMax;
      bit_q         <= 1'b0;
      clr_q         <= '0;
      out_valid_q   <= 1'b0;
      res_bit_q     <= 1'b0;
      res_owed_q    <= '0;
      res_refused_q <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        abad_pkg::S_CLEAR: clr_q <= clr_q + CONTEXT_BITS'(1);
        abad_pkg::S_IDLE: begin
          if (accept) begin
            if (action_i == abad_pkg::ActFeed) begin
              // A feed with nothing owed drops the byte.
              res_bit_q     <= 1'b0;
              res_refused_q <= (owed_q == '0);
              if (owed_q != '0) begin
                code_q     <= {code_q[RW-9:0], data_byte_i};
                owed_q     <= owed_q - OW'(1);
                res_owed_q <= owed_q - OW'(1);
              end else begin
                res_owed_q <= owed_q;
              end
            end else if (owed_q != '0) begin
              res_bit_q     <= 1'b0;
              res_refused_q <= 1'b1;
              res_owed_q    <= owed_q;
            end
          end
        end
        abad_pkg::S_BIT: begin
          bit_q <= is_one;
          ctx_q <= CONTEXT_BITS'({ctx_q, is_one});
          if (is_one) begin
            high_q <= mid_q;
          end else begin
            low_q <= mid_q + RW'(1);
          end
        end
        abad_pkg::S_DIV: begin
          // Renormalization runs alongside the divider, a byte per cycle.
          if (renorm) begin
            low_q  <= {low_q[RW-9:0], 8'h00};
            high_q <= {high_q[RW-9:0], 8'hFF};
            owed_q <= owed_q + OW'(1);
          end
          if (div_done) begin
            prob_q <= div_quot;
          end
        end
        abad_pkg::S_DONE: begin
          if (out_free) begin
            res_bit_q     <= bit_q;
            res_refused_q <= 1'b0;
            res_owed_q    <= owed_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign decoded_bit_o = res_bit_q;
  assign bytes_owed_o  = res_owed_q;
  assign refused_o     = res_refused_q;

endmodule
`default_nettype wire

// ===== bench/abad_reply_checker.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// abad_reply_checker
// Watches both channels of the arithmetic decoder, keeps its own copy of the
// interval, code register and count model, works out the reply to every
// accepted request and compares each returned reply with the oldest one due.
// -----------------------------------------------------------------------------
module abad_reply_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_i,
  input  wire logic                       action_i,
  input  wire logic [7:0]                 data_byte_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_ready_i,
  input  wire logic                       decoded_bit_i,
  input  wire logic [abad_pkg::OwedW-1:0] bytes_owed_i,
  input  wire logic                       refused_i,
  output int                              fail_count_o,
  output logic [abad_pkg::OwedW-1:0]      owed_o,
  output int                              outstanding_o
);

  localparam int unsigned RangeW = abad_pkg::RangeW;
  localparam int unsigned ProbW  = abad_pkg::ProbW;
  localparam int unsigned CountW = abad_pkg::CountW;
  localparam int unsigned OwedW  = abad_pkg::OwedW;
  localparam int unsigned CtxW   = abad_pkg::ContextBits;
  localparam int unsigned NumCtx = 1 << CtxW;

  typedef struct packed {
    logic             decoded;
    logic [OwedW-1:0] owed;
    logic             refused;
  } reply_t;

  logic [RangeW-1:0] lo_q;
  logic [RangeW-1:0] hi_q;
  logic [RangeW-1:0] code_q;
  logic [CtxW-1:0]   ctx_q;
  logic [ProbW-1:0]  prob_q;
  logic [CountW-1:0] zero_cnt [NumCtx];
  logic [CountW-1:0] one_cnt  [NumCtx];
  logic [OwedW-1:0]  owed_q;

  reply_t replies_due [$];
  int     mismatches = 0;
  int     waiting = 0;

  assign fail_count_o  = mismatches;
  assign outstanding_o = waiting;
  assign owed_o        = owed_q;

  task automatic clear_model();
    lo_q   = '0;
    hi_q   = '1;
    code_q = '0;
    ctx_q  = '0;
    prob_q = abad_pkg::ProbReset;
    owed_q = abad_pkg::OwedMax;
    for (int i = 0; i < NumCtx; i++) begin
      zero_cnt[i] = '0;
      one_cnt[i]  = '0;
    end
  endtask

  // Counts one more y in context c; a count passing the limit halves the pair.
  task automatic bump_count(input logic [CtxW-1:0] c, input logic y);
    logic [CountW:0] bumped;
    bumped = y ? {1'b0, one_cnt[c]} + (CountW+1)'(1)
               : {1'b0, zero_cnt[c]} + (CountW+1)'(1);
    if (bumped > abad_pkg::CountLim) begin
      if (y) begin
        one_cnt[c]  = bumped[CountW:1];
        zero_cnt[c] = zero_cnt[c] >> 1;
      end else begin
        zero_cnt[c] = bumped[CountW:1];
        one_cnt[c]  = one_cnt[c] >> 1;
      end
    end else if (y) begin
      one_cnt[c] = bumped[CountW-1:0];
    end else begin
      zero_cnt[c] = bumped[CountW-1:0];
    end
  endtask

  task automatic decode_request(input logic act, input logic [7:0] byte_val,
                                output reply_t reply);
    logic [RangeW-1:0] mid;
    logic [RangeW-1:0] num;
    logic [RangeW-1:0] den;
    logic              y;
    reply = '0;
    if (act == abad_pkg::ActFeed) begin
      if (owed_q == '0) begin
        reply.refused = 1'b1;
      end else begin
        code_q = {code_q[RangeW-9:0], byte_val};
        owed_q = owed_q - OwedW'(1);
      end
    end else if (owed_q != '0) begin
      reply.refused = 1'b1;
    end else begin
      mid = lo_q + ((hi_q - lo_q) >> 32) * RangeW'(prob_q);
      y   = (code_q <= mid);
      if (y) hi_q = mid;
      else   lo_q = mid + RangeW'(1);
      bump_count(ctx_q, y);
      ctx_q  = {ctx_q[CtxW-2:0], y};
      num    = (RangeW'(one_cnt[ctx_q]) + RangeW'(1)) << 32;
      den    = RangeW'(zero_cnt[ctx_q]) + RangeW'(one_cnt[ctx_q]) + RangeW'(2);
      prob_q = ProbW'(num / den);
      // Shift out settled top bytes; each one owes a fresh input byte.
      while ((lo_q[RangeW-1 -: 8] == hi_q[RangeW-1 -: 8]) &&
             (owed_q < abad_pkg::OwedMax)) begin
        lo_q   = lo_q << 8;
        hi_q   = {hi_q[RangeW-9:0], 8'hFF};
        owed_q = owed_q + OwedW'(1);
      end
      reply.decoded = y;
    end
    reply.owed = owed_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    reply_t got;
    if (!rst_ni) begin
      clear_model();
      replies_due.delete();
      waiting = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        decode_request(action_i, data_byte_i, want);
        replies_due.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        got = '{decoded: decoded_bit_i, owed: bytes_owed_i, refused: refused_i};
        if (replies_due.size() == 0) begin
          $display("%0t: reply with none due: bit %0d owed %0d refused %0d",
                   $time, got.decoded, got.owed, got.refused);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (got.decoded !== want.decoded) begin
            $display("%0t: decoded_bit expected %0d, got %0d",
                     $time, want.decoded, got.decoded);
            mismatches++;
          end
          if (got.owed !== want.owed) begin
            $display("%0t: bytes_owed expected %0d, got %0d",
                     $time, want.owed, got.owed);
            mismatches++;
          end
          if (got.refused !== want.refused) begin
            $display("%0t: refused expected %0d, got %0d",
                     $time, want.refused, got.refused);
            mismatches++;
          end
        end
      end
      waiting = replies_due.size();
    end
  end

endmodule

// ===== bench/tb_adaptive_binary_arithmetic_decoder.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_adaptive_binary_arithmetic_decoder
// Drives feed and decode requests into the decoder, mostly as well-formed
// streams of random compressed bytes with some stray requests mixed in, under
// three idling patterns and one long output stall, and reports the verdict.
// -----------------------------------------------------------------------------
module tb_adaptive_binary_arithmetic_decoder;

  localparam int CycleLimit   = 1_000_000;
  localparam int PhaseItems   = 300;
  localparam int HoldCycles   = 200;
  localparam int SettleCycles = 60;
  localparam int NoisePct     = 15;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       action = abad_pkg::ActFeed;
  logic [7:0]                 data_byte = 8'h00;
  logic                       out_ready = 1'b0;
  logic                       in_ready;
  logic                       out_valid;
  logic                       decoded_bit;
  logic [abad_pkg::OwedW-1:0] bytes_owed;
  logic                       refused;

  int                         fail_count;
  int                         outstanding;
  logic [abad_pkg::OwedW-1:0] owed_pred;

  int tx_idle_pct = 29;
  int rx_idle_pct = 50;
  int hold_requests = 0;
  int holds_done = 0;
  int cycle_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  adaptive_binary_arithmetic_decoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .data_byte_i   (data_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .decoded_bit_o (decoded_bit),
    .bytes_owed_o  (bytes_owed),
    .refused_o     (refused)
  );

  abad_reply_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .action_i      (action),
    .data_byte_i   (data_byte),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .decoded_bit_i (decoded_bit),
    .bytes_owed_i  (bytes_owed),
    .refused_i     (refused),
    .fail_count_o  (fail_count),
    .owed_o        (owed_pred),
    .outstanding_o (outstanding)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output side: random back-pressure, plus a long hold-off when requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        holds_done++;
      end
      out_ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer(input logic act, input logic [7:0] byte_val);
    in_valid  = 1'b1;
    action    = act;
    data_byte = byte_val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Feeds while bytes are owed and decodes otherwise, with some stray requests.
  task automatic stream_request(input int noise_pct, input logic [7:0] byte_val);
    logic act;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      if ($urandom_range(9) == 0) repeat ($urandom_range(45, 10)) @(negedge clk);
      else repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    if (noise_pct != 0 && $urandom_range(99) < noise_pct) begin
      act = ($urandom_range(1) == 1) ? abad_pkg::ActDecode : abad_pkg::ActFeed;
    end else begin
      act = (owed_pred == '0) ? abad_pkg::ActDecode : abad_pkg::ActFeed;
    end
    offer(act, byte_val);
  endtask

  task automatic drain_replies();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    logic [7:0] fill_bytes [8];
    logic [7:0] edge_bytes [4];
    logic [7:0] rand_byte;
    fill_bytes = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hFF, 8'h7F, 8'hFE, 8'h55};
    edge_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA};
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Decoding before the code register is filled must be refused.
    offer(abad_pkg::ActDecode, 8'hA5);
    foreach (fill_bytes[i]) offer(abad_pkg::ActFeed, fill_bytes[i]);
    // Nothing is owed now, so a feed must be refused.
    offer(abad_pkg::ActFeed, 8'hAA);
    for (int i = 0; i < 13; i++) stream_request(0, edge_bytes[i % 4]);
    drain_replies();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 29;
          rx_idle_pct = 50;
        end
        1: begin
          tx_idle_pct = 50;
          rx_idle_pct = 29;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_requests++;
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        // End of stream shows up as zero bytes now and then.
        rand_byte = ($urandom_range(19) == 0) ? 8'h00 : 8'($urandom_range(255));
        stream_request(NoisePct, rand_byte);
      end
      drain_replies();
    end

    repeat (SettleCycles) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
